// ===== design/ptrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_pkg
// shared types and constants for the pairwise tail ratio statistic unit
// ----------------------------------------------------------------------------
package ptrs_pkg;
   localparam int MaxSamples = 1024;
   localparam int SampleBits = 32;
   localparam int FracBits   = 16;
   localparam int AddrBits   = $clog2(MaxSamples);
   localparam int CountBits  = AddrBits + 1;
   localparam int SumBits    = SampleBits + 1;
   localparam int QBits      = FracBits + 1;
   localparam int RSumBits   = 36;
   localparam int PairBits   = 20;
   localparam int DenBits    = 2 * CountBits;
   localparam int DivBits    = RSumBits + FracBits;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FEW      = 2'd1,
      ST_NO_PAIRS = 2'd2,
      ST_DROPPED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FIN_DIV,
      S_FIN_WAIT,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      DIV_GAMMA,
      DIV_MEAN,
      DIV_FRAC
   } div_sel_type;

   typedef struct packed {
      logic        take;
      logic        store;
      logic        scan;
      logic        clear;
      logic        div_start;
      div_sel_type div_sel;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic pipe_empty;
      logic div_busy;
      logic few;
      logic no_pairs;
   } sts_type;
endpackage
`default_nettype wire

// ===== design/ptrs_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_datapath
// sample store, pair pipeline with staged divider, accumulators, final divides
// ----------------------------------------------------------------------------
module ptrs_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [ptrs_pkg::SampleBits-1:0]   sample,
   input  wire logic [31:0]                       threshold,
   input  wire ptrs_pkg::cmd_type                 cmd,
   output ptrs_pkg::sts_type                      sts,
   output logic                                   full,
   output logic [ptrs_pkg::QBits-1:0]             gamma_ratio,
   output logic [ptrs_pkg::QBits-1:0]             mean_ratio,
   output logic [ptrs_pkg::QBits-1:0]             pair_fraction,
   output logic [18:0]                            pair_count,
   output ptrs_pkg::status_type                   status
);
   import ptrs_pkg::*;
   localparam int Stages = QBits;

   logic [SampleBits-1:0] mem [MaxSamples];
   logic [SampleBits-1:0] x_ff, x_in, rd_ff;
   logic [CountBits-1:0]  cnt_ff, cnt_in, k_ff, k_in;
   logic                  ovf_ff, ovf_in, rdv_ff;
   logic [RSumBits-1:0]   rsum_ff, rsum_in;
   logic [PairBits-1:0]   pairs_ff, pairs_in;

   // pair pipeline: stage 0 forms sum and diff, then one quotient bit a stage
   logic                v_ff  [Stages+1];
   logic [SumBits-1:0]  den_ff[Stages+1];
   logic [SumBits:0]    rem_ff[Stages+1];
   logic [QBits-1:0]    q_ff  [Stages+1];

   logic [SumBits-1:0] s0, d0;
   logic [SumBits-1:0] thr_ext;
   assign s0 = {1'b0, x_ff} + {1'b0, rd_ff};
   assign d0 = (x_ff >= rd_ff) ? {1'b0, x_ff - rd_ff} : {1'b0, rd_ff - x_ff};
   assign thr_ext = SumBits'(threshold);

   always_ff @(posedge clock) begin
      if (cmd.store) mem[cnt_ff[AddrBits-1:0]] <= sample;
      rd_ff <= mem[k_ff[AddrBits-1:0]];
   end

   always_comb begin
      x_in = cmd.take ? sample : x_ff;
      k_in = k_ff;
      if (cmd.take) k_in = '0;
      else if (cmd.scan) k_in = k_ff + 1'b1;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (cmd.store) cnt_in = cnt_ff + 1'b1;
      if (cmd.take && !cmd.store) ovf_in = 1'b1;
      rsum_in = rsum_ff;
      pairs_in = pairs_ff;
      if (v_ff[Stages]) begin
         rsum_in = rsum_ff + RSumBits'(q_ff[Stages]);
         pairs_in = pairs_ff + 1'b1;
      end
      if (cmd.clear) begin
         cnt_in = '0; ovf_in = 1'b0; rsum_in = '0; pairs_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; ovf_ff <= 1'b0; rsum_ff <= '0; pairs_ff <= '0;
         k_ff <= '0; rdv_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; ovf_ff <= ovf_in; rsum_ff <= rsum_in;
         pairs_ff <= pairs_in; k_ff <= k_in; rdv_ff <= cmd.scan;
      end
      x_ff <= x_in;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else v_ff[0] <= rdv_ff && (s0 > thr_ext);
      den_ff[0] <= s0;
      rem_ff[0] <= {1'b0, d0};
      q_ff[0]   <= '0;
   end

   for (genvar g = 1; g <= Stages; g++) begin : g_div
      logic [SumBits:0] r;
      logic             ge;
      assign r  = (g == 1) ? rem_ff[g-1] : {rem_ff[g-1][SumBits-1:0], 1'b0};
      assign ge = r >= {1'b0, den_ff[g-1]};
      always_ff @(posedge clock) begin
         if (reset) v_ff[g] <= 1'b0;
         else v_ff[g] <= v_ff[g-1];
         den_ff[g] <= den_ff[g-1];
         rem_ff[g] <= ge ? r - {1'b0, den_ff[g-1]} : r;
         q_ff[g]   <= {q_ff[g-1][QBits-2:0], ge};
      end
   end

   logic any_v;
   always_comb begin
      any_v = rdv_ff;
      for (int i = 0; i <= Stages; i++) any_v = any_v | v_ff[i];
   end

   // final divides: shared restoring divider, one bit a cycle
   logic [DenBits-1:0]  nn;
   logic [DenBits-1:0]  cnt_m1;
   logic [DivBits-1:0]  dq_ff, dq_in;
   logic [DenBits:0]    dr_ff, dr_in;
   logic [DenBits-1:0]  dd_ff, dd_in;
   logic [6:0]          dn_ff, dn_in;
   logic                busy_ff, busy_in;
   div_sel_type         dsel_ff, dsel_in;
   logic [DenBits-1:0]  denom_ff;
   logic [QBits-1:0]    g_ff, m_ff, f_ff;
   logic [QBits-1:0]    g_in, m_in, f_in;
   logic [DenBits:0]    trial;

   assign cnt_m1 = DenBits'(cnt_ff - 1'b1);
   assign nn = DenBits'(cnt_ff) * cnt_m1;

   always_ff @(posedge clock) denom_ff <= nn >> 1;

   assign trial = {dr_ff[DenBits-1:0], dq_ff[DivBits-1]};

   always_comb begin
      dq_in = dq_ff; dr_in = dr_ff; dd_in = dd_ff; dn_in = dn_ff;
      busy_in = busy_ff; dsel_in = dsel_ff;
      g_in = g_ff; m_in = m_ff; f_in = f_ff;
      if (cmd.div_start) begin
         busy_in = 1'b1; dsel_in = cmd.div_sel; dr_in = '0;
         dn_in = 7'(DivBits);
         unique case (cmd.div_sel)
            DIV_GAMMA: begin
               dq_in = DivBits'(rsum_ff); dd_in = DenBits'(pairs_ff);
            end
            DIV_MEAN: begin
               dq_in = DivBits'(rsum_ff); dd_in = denom_ff;
            end
            default: begin
               dq_in = DivBits'(pairs_ff) << FracBits; dd_in = denom_ff;
            end
         endcase
      end else if (busy_ff) begin
         if (trial >= {1'b0, dd_ff}) begin
            dr_in = trial - {1'b0, dd_ff};
            dq_in = {dq_ff[DivBits-2:0], 1'b1};
         end else begin
            dr_in = trial;
            dq_in = {dq_ff[DivBits-2:0], 1'b0};
         end
         dn_in = dn_ff - 1'b1;
         if (dn_ff == 7'd1) begin
            busy_in = 1'b0;
            case (dsel_ff)
               DIV_GAMMA: g_in = dq_in[QBits-1:0];
               DIV_MEAN:  m_in = dq_in[QBits-1:0];
               default:   f_in = dq_in[QBits-1:0];
            endcase
         end
      end
   end

   // dividend shifts out the top as quotient bits enter the bottom
   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      dq_ff <= dq_in; dr_ff <= dr_in; dd_ff <= dd_in; dn_ff <= dn_in;
      dsel_ff <= dsel_in; g_ff <= g_in; m_ff <= m_in; f_ff <= f_in;
   end

   logic few, nop;
   assign few = cnt_ff < CountBits'(2);
   assign nop = pairs_ff == '0;
   assign full = (cnt_ff == CountBits'(MaxSamples));

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (few || nop) begin
            gamma_ratio <= '0; mean_ratio <= '0; pair_fraction <= '0; pair_count <= '0;
            status <= few ? ST_FEW : ST_NO_PAIRS;
         end else begin
            gamma_ratio <= g_ff; mean_ratio <= m_ff; pair_fraction <= f_ff;
            pair_count <= pairs_ff[18:0];
            status <= ovf_ff ? ST_DROPPED : ST_OK;
         end
      end
   end

   // the new sample is already counted, so the scan stops one short of cnt
   always_comb begin
      sts.scan_done  = ((k_ff + CountBits'(1)) >= cnt_ff);
      sts.pipe_empty = !any_v;
      sts.div_busy   = busy_ff;
      sts.few        = few;
      sts.no_pairs   = nop;
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> busy_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> cnt_ff < CountBits'(MaxSamples))
      else $error("store beyond capacity");
   assert property (@(posedge clock) disable iff (reset)
      v_ff[Stages] |-> q_ff[Stages] <= QBits'(1 << FracBits))
      else $error("pair ratio above one");
endmodule
`default_nettype wire

// ===== design/ptrs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_ctrl
// sequencer for sample intake, pair scan, final divides and result handoff
// ----------------------------------------------------------------------------
module ptrs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic               req_tlast,
   input  wire logic               full,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output ptrs_pkg::cmd_type       cmd,
   input  wire ptrs_pkg::sts_type  sts
);
   import ptrs_pkg::*;

   state_type   state_ff, state_in;
   logic        last_ff, last_in, ovalid_ff, ovalid_in;
   div_sel_type sel_ff, sel_in;
   logic        acc;

   assign acc = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff; last_in = last_ff; sel_in = sel_ff;
      ovalid_in = ovalid_ff;
      if (rsp_tready) ovalid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (acc) begin
            last_in = req_tlast;
            state_in = full ? (req_tlast ? S_DRAIN : S_IDLE) : S_SCAN;
         end
         S_SCAN: if (sts.scan_done) state_in = S_DRAIN;
         S_DRAIN: if (sts.pipe_empty) begin
            if (!last_ff) state_in = S_IDLE;
            else if (sts.few || sts.no_pairs) state_in = S_OUT;
            else begin
               sel_in = DIV_GAMMA; state_in = S_FIN_DIV;
            end
         end
         S_FIN_DIV: state_in = S_FIN_WAIT;
         S_FIN_WAIT: if (!sts.div_busy) begin
            unique case (sel_ff)
               DIV_GAMMA: begin sel_in = DIV_MEAN; state_in = S_FIN_DIV; end
               DIV_MEAN:  begin sel_in = DIV_FRAC; state_in = S_FIN_DIV; end
               default:   state_in = S_OUT;
            endcase
         end
         S_OUT: if (!ovalid_ff || rsp_tready) begin
            ovalid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.div_sel = sel_ff;
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = ovalid_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = acc;
            cmd.store = acc && !full;
         end
         S_SCAN:  cmd.scan = !sts.scan_done;
         S_FIN_DIV: cmd.div_start = 1'b1;
         S_OUT: begin
            cmd.rsp_load = !ovalid_ff || rsp_tready;
            cmd.clear = cmd.rsp_load;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; last_ff <= 1'b0; sel_ff <= DIV_GAMMA; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; last_ff <= last_in; sel_ff <= sel_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_tvalid)
      else $error("result not presented");
   assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> cmd.take)
      else $error("store without intake");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN_DIV) |-> !sts.div_busy)
      else $error("divider restarted while busy");
endmodule
`default_nettype wire

// ===== design/pairwise_tail_ratio_statistic_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pairwise_tail_ratio_statistic_unit
// tail ratio statistic over all sample pairs of a set
// ----------------------------------------------------------------------------
// Samples (unsigned Q16.16) arrive one per beat; each is paired with every
// sample already stored in the set through a one-pair-per-cycle pipelined
// divider (17 quotient stages). Before the next beat is accepted, each
// stored sample is scanned against the samples stored before it (up to
// 1023) through the read port of the sample memory, and the pipeline
// drains. After the last beat the final divides run in a shared
// bit-serial divider, skipped when there are fewer than two samples or no
// pairs. A result beat carries gamma, mean over all pairs, pair fraction,
// pair count and status; the result register lets the next set start while
// a result waits.
module pairwise_tail_ratio_statistic_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // sample
   input  wire logic        req_tlast,   // last sample of the set
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // gamma_ratio[16:0], mean_ratio_all_pairs[33:17], pair_fraction[50:34],
   // pair_count[69:51], status[71:70]
   output logic [71:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data   // pair_sum_threshold
);
   import ptrs_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [31:0] thr_ff;
   logic [QBits-1:0] g, m, f;
   logic [18:0] pc;
   status_type st;
   logic full;

   // threshold register, meant to be written between sets
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= '0;
      else if (csr_valid) thr_ff <= csr_data;
   end

   ptrs_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_tlast,
      .full, .rsp_tvalid, .rsp_tready, .cmd, .sts
   );

   ptrs_datapath u_dp (
      .clock, .reset, .sample(req_tdata[SampleBits-1:0]), .threshold(thr_ff),
      .cmd, .sts, .full, .gamma_ratio(g), .mean_ratio(m), .pair_fraction(f),
      .pair_count(pc), .status(st)
   );

   assign rsp_tdata = {st, pc, f, m, g};
endmodule
`default_nettype wire
